// ===== design/mrp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrp_pkg: shared types and codes of the marker record parser
// Segment geometry, header codes, result kinds, and parser state/result structs.
// ----------------------------------------------------------------------------
package mrp_pkg;

	localparam int SEG_WORDS = 16;
	localparam int POS_W     = $clog2(SEG_WORDS);
	localparam int TOTAL_W   = 48;
	localparam int BLOCKS_W  = 35;

	// segment header codes (low byte of word 0)
	localparam logic [7:0] HDR_TRIGGER  = 8'h01;
	localparam logic [7:0] HDR_GATE     = 8'h04;
	localparam logic [7:0] HDR_GATE_ALT = 8'h0a;
	localparam logic [7:0] HDR_DUMMY    = 8'h08;

	// segment kind held across a segment
	localparam logic [1:0] SEG_SKIP    = 2'd0;
	localparam logic [1:0] SEG_TRIGGER = 2'd1;
	localparam logic [1:0] SEG_GATE    = 2'd2;

	// result kinds
	localparam logic [2:0] K_TRIGGER   = 3'd0;
	localparam logic [2:0] K_GATE      = 3'd1;
	localparam logic [2:0] K_GATE_DROP = 3'd2;
	localparam logic [2:0] K_READ_DONE = 3'd3;
	localparam logic [2:0] K_BAD_HDR   = 3'd4;
	localparam logic [2:0] K_DUMMY     = 3'd5;
	localparam logic [2:0] K_REVERSED  = 3'd6;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct packed {
		logic [POS_W-1:0]   word_pos;
		logic [1:0]         seg_kind;
		logic [31:0]        held_word;
		logic [31:0]        held_start;
		logic [7:0]         held_sample;
		logic               sub_is_gate;
		logic [15:0]        trig_seen;
		logic               any_trig;
		logic [TOTAL_W-1:0] gate_sum;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [55:0]         timestamp;
		logic [23:0]         trigger_index;
		logic [7:0]          sub_sample;
		logic [31:0]         start_block;
		logic [7:0]          start_sample;
		logic [31:0]         end_block;
		logic [7:0]          end_sample;
		logic [BLOCKS_W-1:0] gate_blocks;
		logic [TOTAL_W-1:0]  read_total;
		logic [15:0]         trigger_count;
	} result_t;

endpackage
`default_nettype wire

// ===== design/mrp_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrp_step: per-word parse logic
// Given the parser state and one marker word, forms the next state and the
// result (if any) that the word produces.
// ----------------------------------------------------------------------------
module mrp_step
	import mrp_pkg::*;
(
	input  wire parse_state_t st,
	input  wire logic [31:0]  word,
	input  wire logic [15:0]  trig_limit,
	output parse_state_t      nx,
	output logic              res_valid,
	output result_t           res
);

	logic [1:0]          seg;
	logic [31:0]         end_blk;
	logic [31:0]         diff;
	logic [BLOCKS_W-1:0] quad;
	logic [BLOCKS_W-1:0] blocks;
	logic                reversed;
	logic [TOTAL_W:0]    sum;

	always_comb begin
		nx        = st;
		res       = '0;
		res_valid = 1'b0;
		seg       = st.seg_kind;

		end_blk  = {word[23:0], st.held_word[31:24]};
		reversed = end_blk < st.held_start;
		diff     = end_blk - st.held_start;
		quad     = {1'b0, diff, 2'b00};
		// round up to a multiple of 16
		blocks   = reversed ? '0 : ((quad + BLOCKS_W'(12)) & ~BLOCKS_W'(15));
		sum      = {1'b0, st.gate_sum} + {{(TOTAL_W + 1 - BLOCKS_W){1'b0}}, blocks};

		if (st.word_pos == '0) begin
			nx.held_word = word;
			case (word[7:0])
				HDR_TRIGGER: begin
					seg = SEG_TRIGGER;
					if (({1'b0, st.trig_seen} + 17'd1) > {1'b0, trig_limit}) begin
						res_valid         = 1'b1;
						res.kind          = K_READ_DONE;
						res.read_total    = st.gate_sum;
						res.trigger_count = st.trig_seen;
						nx.gate_sum       = '0;
						nx.any_trig       = 1'b0;
						nx.trig_seen      = 16'd1;
					end else begin
						nx.trig_seen = st.trig_seen + 16'd1;
					end
				end
				HDR_GATE, HDR_GATE_ALT: begin
					seg = SEG_GATE;
				end
				HDR_DUMMY: begin
					seg               = SEG_SKIP;
					res_valid         = 1'b1;
					res.kind          = K_DUMMY;
					res.read_total    = st.gate_sum;
					res.trigger_count = st.trig_seen;
				end
				default: begin
					seg               = SEG_SKIP;
					res_valid         = 1'b1;
					res.kind          = K_BAD_HDR;
					res.read_total    = st.gate_sum;
					res.trigger_count = st.trig_seen;
				end
			endcase
		end

		if (seg == SEG_TRIGGER) begin
			if (st.word_pos == POS_W'(1)) begin
				nx.held_start  = {8'd0, word[31:8]};
				nx.held_sample = word[7:0];
			end else if (st.word_pos == POS_W'(2)) begin
				nx.any_trig       = 1'b1;
				res_valid         = 1'b1;
				res.kind          = K_TRIGGER;
				res.timestamp     = {word, st.held_start[23:0]};
				res.trigger_index = st.held_word[31:8];
				res.sub_sample    = st.held_sample;
				res.read_total    = st.gate_sum;
				res.trigger_count = st.trig_seen;
			end
		end else if (seg == SEG_GATE) begin
			case (st.word_pos[1:0])
				2'd0: begin
					nx.sub_is_gate = (word[7:0] == HDR_GATE);
					nx.held_word   = word;
				end
				2'd1: begin
					nx.held_start  = {word[23:0], st.held_word[31:24]};
					nx.held_sample = word[31:24];
				end
				2'd2: begin
					nx.held_word = word;
				end
				default: begin
					if (st.sub_is_gate) begin
						res_valid        = 1'b1;
						res.start_block  = st.held_start;
						res.start_sample = st.held_sample;
						res.end_block    = end_blk;
						res.end_sample   = word[31:24];
						res.gate_blocks  = blocks;
						if (!st.any_trig) begin
							res.kind = K_GATE_DROP;
							seg      = SEG_SKIP;
						end else if (reversed) begin
							res.kind = K_REVERSED;
						end else begin
							res.kind    = K_GATE;
							nx.gate_sum = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
						end
						res.read_total    = nx.gate_sum;
						res.trigger_count = st.trig_seen;
					end
				end
			endcase
		end

		nx.seg_kind = seg;
		nx.word_pos = (st.word_pos == POS_W'(SEG_WORDS - 1)) ? '0 : st.word_pos + POS_W'(1);
	end

endmodule
`default_nettype wire

// ===== design/marker_record_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// marker_record_parser: digitizer marker stream parser
// Parses 16-word marker segments into trigger, gate, read-done, dummy and bad-header results.
// ----------------------------------------------------------------------------
// Usage
//   Marker words enter on marker_word with marker_valid/marker_stall; a
//   transfer happens on a clock edge with valid high and stall low.
//   Results leave on result_valid/result_stall with one port per field;
//   fields a result kind does not use read as zero.
//   Each word is registered (s1), parsed against the running segment state in
//   one pass, and any result lands in the output register (s2), which drives
//   result_valid. Throughput is one word per cycle while result_stall does
//   not hold a waiting result; the output register lets the next word
//   be parsed in the same cycle that the waiting result is taken.
//   When result_stall holds a waiting result, the word in s1 waits too and
//   marker_stall rises until the output register frees.
//   The trigger limit per read is written through cfg_wr_en/cfg_wr_data
//   while idle.
//   Reset (arst_n low) returns to the start of a segment with zero counts,
//   an empty pipeline and a limit of one trigger per read.
// ----------------------------------------------------------------------------
module marker_record_parser
	import mrp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_wr_en,
	input  wire logic [15:0]         cfg_wr_data,
	// marker word channel
	input  wire logic                marker_valid,
	output logic                     marker_stall,
	input  wire logic [31:0]         marker_word,
	// result channel
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [2:0]               kind,
	output logic [55:0]              timestamp,
	output logic [23:0]              trigger_index,
	output logic [7:0]               sub_sample,
	output logic [31:0]              start_block,
	output logic [7:0]               start_sample,
	output logic [31:0]              end_block,
	output logic [7:0]               end_sample,
	output logic [BLOCKS_W-1:0]      gate_blocks,
	output logic [TOTAL_W-1:0]       read_total,
	output logic [15:0]              trigger_count
);

	logic [15:0]  trig_limit_q;
	parse_state_t state_q;
	parse_state_t state_nx;

	logic         valid_s1;
	logic [31:0]  word_s1;
	logic         valid_s2;
	result_t      res_s2;

	logic         step_res_valid;
	result_t      step_res;
	logic         advance;
	logic         accept;

	// s1 word moves on once the output register is empty or being drained
	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign marker_stall = valid_s1 && !advance;
	assign accept       = marker_valid && !marker_stall;

	mrp_step u_step (
		.st         (state_q),
		.word       (word_s1),
		.trig_limit (trig_limit_q),
		.nx         (state_nx),
		.res_valid  (step_res_valid),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_limit_q <= 16'd1;
		end else if (cfg_wr_en) begin
			trig_limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= marker_word;
		end
	end

	// segment state: updated once per parsed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_res_valid;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res_valid) begin
			res_s2 <= step_res;
		end
	end

	assign result_valid  = valid_s2;
	assign kind          = res_s2.kind;
	assign timestamp     = res_s2.timestamp;
	assign trigger_index = res_s2.trigger_index;
	assign sub_sample    = res_s2.sub_sample;
	assign start_block   = res_s2.start_block;
	assign start_sample  = res_s2.start_sample;
	assign end_block     = res_s2.end_block;
	assign end_sample    = res_s2.end_sample;
	assign gate_blocks   = res_s2.gate_blocks;
	assign read_total    = res_s2.read_total;
	assign trigger_count = res_s2.trigger_count;

	// state moves only when a word is parsed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("parser state changed without a parsed word");

	// word position steps by one per parsed word
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (state_q.word_pos != POS_W'(SEG_WORDS - 1))
		|=> state_q.word_pos == $past(state_q.word_pos) + POS_W'(1))
		else $error("word position skipped");

	// a read-done result opens a new read with one trigger and no blocks
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res_valid && (step_res.kind == K_READ_DONE)
		|=> (state_q.gate_sum == '0) && (state_q.trig_seen == 16'd1))
		else $error("read done did not restart the read");

	// a parsed word with a result always reaches the output register
	a_res_capture: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res_valid |=> valid_s2)
		else $error("result lost");

endmodule
`default_nettype wire

// ===== dv/mrp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrp_checker: result predictor and scoreboard for the marker record parser
// Tracks the register and the segment state from the observed transfers,
// queues the expected result of each word that yields one, checks every result.
// ----------------------------------------------------------------------------
module mrp_checker
	import mrp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                marker_valid,
	input  logic                marker_stall,
	input  logic [31:0]         marker_word,
	input  logic                result_valid,
	input  logic                result_stall,
	input  logic [2:0]          kind,
	input  logic [55:0]         timestamp,
	input  logic [23:0]         trigger_index,
	input  logic [7:0]          sub_sample,
	input  logic [31:0]         start_block,
	input  logic [7:0]          start_sample,
	input  logic [31:0]         end_block,
	input  logic [7:0]          end_sample,
	input  logic [BLOCKS_W-1:0] gate_blocks,
	input  logic [TOTAL_W-1:0]  read_total,
	input  logic [15:0]         trigger_count,
	output int                  pending,
	output int                  fail_count
);

	logic [15:0]        trig_limit;
	logic [POS_W-1:0]   pos_in_seg;
	logic [1:0]         cur_seg;
	logic [31:0]        latched_word;
	logic [31:0]        latched_start;
	logic [7:0]         latched_sample;
	logic               sub_gate;
	logic [16:0]        trig_in_read;
	logic               trig_armed;
	logic [TOTAL_W-1:0] blocks_in_read;

	result_t expected_results[$];
	int      mismatches = 0;

	function automatic result_t read_summary(input logic [2:0] k);
		result_t r;
		r = '0;
		r.kind = k;
		r.read_total = blocks_in_read;
		r.trigger_count = trig_in_read[15:0];
		return r;
	endfunction

	// advances the parse state by one word; returns 1 when the word yields a result
	function automatic bit predict_marker_word(input logic [31:0] w, output result_t r);
		logic [POS_W-1:0] pos;
		bit               hit;
		logic [31:0]      eb;
		logic [34:0]      blk;
		logic [48:0]      sum;
		logic [2:0]       k;
		bit               rev;
		pos = pos_in_seg;
		hit = 1'b0;
		r = '0;
		if (pos == 0) begin
			latched_word = w;
			case (w[7:0])
				HDR_TRIGGER: begin
					cur_seg = SEG_TRIGGER;
					// the trigger past the limit closes the read and opens the next
					if (int'(trig_in_read) + 1 > int'(trig_limit)) begin
						r = read_summary(K_READ_DONE);
						hit = 1'b1;
						blocks_in_read = '0;
						trig_armed = 1'b0;
						trig_in_read = 17'd1;
					end else begin
						trig_in_read++;
					end
				end
				HDR_GATE, HDR_GATE_ALT: cur_seg = SEG_GATE;
				HDR_DUMMY: begin
					cur_seg = SEG_SKIP;
					r = read_summary(K_DUMMY);
					hit = 1'b1;
				end
				default: begin
					cur_seg = SEG_SKIP;
					r = read_summary(K_BAD_HDR);
					hit = 1'b1;
				end
			endcase
		end

		if (cur_seg == SEG_TRIGGER) begin
			if (pos == 1) begin
				latched_start = {8'h00, w[31:8]};
				latched_sample = w[7:0];
			end else if (pos == 2) begin
				trig_armed = 1'b1;
				r = read_summary(K_TRIGGER);
				r.timestamp = {w, latched_start[23:0]};
				r.trigger_index = latched_word[31:8];
				r.sub_sample = latched_sample;
				hit = 1'b1;
			end
		end else if (cur_seg == SEG_GATE) begin
			// the header doubles as the first word of the first sub-marker
			case (pos[1:0])
				2'd0: begin
					sub_gate = (w[7:0] == HDR_GATE);
					latched_word = w;
				end
				2'd1: begin
					latched_start = {w[23:0], latched_word[31:24]};
					latched_sample = w[31:24];
				end
				2'd2: latched_word = w;
				default: if (sub_gate) begin
					eb = {w[23:0], latched_word[31:24]};
					rev = eb < latched_start;
					blk = '0;
					if (!rev) begin
						blk = {1'b0, eb - latched_start, 2'b00};
						if (blk[3:0] != 4'd0)
							blk = ((blk >> 4) + 35'd1) << 4;
					end
					if (!trig_armed) begin
						k = K_GATE_DROP;
						cur_seg = SEG_SKIP;
					end else if (rev) begin
						k = K_REVERSED;
					end else begin
						k = K_GATE;
						sum = {1'b0, blocks_in_read} + {14'd0, blk};
						blocks_in_read = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX
							: sum[TOTAL_W-1:0];
					end
					r = read_summary(k);
					r.start_block = latched_start;
					r.start_sample = latched_sample;
					r.end_block = eb;
					r.end_sample = w[31:24];
					r.gate_blocks = blk;
					hit = 1'b1;
				end
			endcase
		end

		pos_in_seg = (pos == SEG_WORDS - 1) ? '0 : pos + 1'b1;
		return hit;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			trig_limit = 16'd1;
			pos_in_seg = '0;
			cur_seg = SEG_SKIP;
			latched_word = '0;
			latched_start = '0;
			latched_sample = '0;
			sub_gate = 1'b0;
			trig_in_read = '0;
			trig_armed = 1'b0;
			blocks_in_read = '0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en)
				trig_limit = cfg_wr_data;
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$error("kind: expected no result, got 0x%0h", kind);
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 64'(want.kind), 64'(kind));
					check_field("timestamp", 64'(want.timestamp), 64'(timestamp));
					check_field("trigger_index", 64'(want.trigger_index),
						64'(trigger_index));
					check_field("sub_sample", 64'(want.sub_sample), 64'(sub_sample));
					check_field("start_block", 64'(want.start_block), 64'(start_block));
					check_field("start_sample", 64'(want.start_sample),
						64'(start_sample));
					check_field("end_block", 64'(want.end_block), 64'(end_block));
					check_field("end_sample", 64'(want.end_sample), 64'(end_sample));
					check_field("gate_blocks", 64'(want.gate_blocks), 64'(gate_blocks));
					check_field("read_total", 64'(want.read_total), 64'(read_total));
					check_field("trigger_count", 64'(want.trigger_count),
						64'(trigger_count));
				end
			end
			if (marker_valid && !marker_stall) begin
				if (predict_marker_word(marker_word, want))
					expected_results.push_back(want);
			end
		end
		pending <= expected_results.size();
		fail_count <= mismatches;
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: marker record parser
// Feeds whole 16-word marker segments: a directed set for headers, sub-marker
// types, gate extremes and read limits, then random segments over several
// limits and idle/stall mixes, a short run of widest gates and a few more
// random segments. mrp_checker predicts and scores every result; this module
// only drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module testbench
	import mrp_pkg::*;
();

	localparam int SEGMENTS_PER_PHASE = 11;
	localparam int NUM_PHASES         = 6;
	// segments of four widest gates each
	localparam int SAT_SEGMENTS       = 2;
	localparam int TAIL_SEGMENTS      = 4;
	localparam int WATCHDOG_LIMIT     = 2000;
	// results pass s1 and s2; give a word with no result time to retire
	localparam int DRAIN_TAIL         = 4;
	localparam int END_TAIL           = 10;

	// header and sub-marker type codes the block does not recognize
	localparam logic [7:0] UNKNOWN_HDR = 8'hFF;
	localparam logic [7:0] OTHER_SUB   = 8'h02;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [15:0]         cfg_wr_data = '0;
	logic                marker_valid = 1'b0;
	logic                marker_stall;
	logic [31:0]         marker_word = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [2:0]          kind;
	logic [55:0]         timestamp;
	logic [23:0]         trigger_index;
	logic [7:0]          sub_sample;
	logic [31:0]         start_block;
	logic [7:0]          start_sample;
	logic [31:0]         end_block;
	logic [7:0]          end_sample;
	logic [BLOCKS_W-1:0] gate_blocks;
	logic [TOTAL_W-1:0]  read_total;
	logic [15:0]         trigger_count;

	int pending;
	int fail_count;

	// idle odds in percent, per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	// the segment being assembled before it goes out
	logic [31:0] seg_buf [SEG_WORDS];

	marker_record_parser u_top (.*);
	mrp_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stall, redrawn every cycle
	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// watchdog: any transfer or register write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (marker_valid && !marker_stall) || (result_valid && !result_stall)
				|| cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// one marker word; idle cycles first, then hold valid until the transfer
	task automatic send_word(input logic [31:0] w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			marker_valid <= 1'b0;
			@(posedge clk);
		end
		marker_valid <= 1'b1;
		marker_word <= w;
		@(posedge clk);
		while (marker_stall)
			@(posedge clk);
	endtask

	task automatic send_segment;
		for (int i = 0; i < SEG_WORDS; i++)
			send_word(seg_buf[i]);
	endtask

	task automatic fill_random;
		foreach (seg_buf[i])
			seg_buf[i] = $urandom;
	endtask

	// four-word sub-marker: block numbers straddle word pairs, low byte first
	task automatic put_sub(input int slot, input logic [7:0] typ, input logic [31:0] sb,
			input logic [7:0] ss, input logic [31:0] eb, input logic [7:0] es);
		logic [31:0] pad;
		pad = $urandom;
		seg_buf[4*slot]     = {sb[7:0], pad[15:0], typ};
		seg_buf[4*slot + 1] = {ss, sb[31:8]};
		seg_buf[4*slot + 2] = {eb[7:0], pad[31:8]};
		seg_buf[4*slot + 3] = {es, eb[31:8]};
	endtask

	// trigger: header index, then {timestamp low 24, sub-sample}, then timestamp high
	task automatic send_trigger(input logic [23:0] idx, input logic [31:0] w1,
			input logic [31:0] w2);
		fill_random();
		seg_buf[0] = {idx, HDR_TRIGGER};
		seg_buf[1] = w1;
		seg_buf[2] = w2;
		send_segment();
	endtask

	task automatic random_segment;
		int          sel;
		int          mode;
		logic [7:0]  hdr;
		logic [7:0]  typ;
		logic [31:0] sb;
		logic [31:0] eb;
		fill_random();
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			seg_buf[0][7:0] = HDR_TRIGGER;
		end else if (sel < 80) begin
			hdr = $urandom_range(0, 1) ? HDR_GATE : HDR_GATE_ALT;
			for (int s = 0; s < 4; s++) begin
				// mostly near-sized gates; some wide, reversed, widest or empty
				mode = $urandom_range(0, 9);
				sb = $urandom;
				if (mode < 6)
					eb = sb + $urandom_range(0, 64);
				else if (mode == 6)
					eb = $urandom;
				else if (mode == 7)
					eb = sb - $urandom_range(1, 300);
				else if (mode == 8) begin
					sb = '0;
					eb = '1;
				end else
					eb = sb;
				if (s == 0)
					typ = hdr;
				else if ($urandom_range(0, 99) < 70)
					typ = HDR_GATE;
				else begin
					typ = 8'($urandom);
					if (typ == HDR_GATE)
						typ = OTHER_SUB;
				end
				put_sub(s, typ, sb, 8'($urandom), eb, 8'($urandom));
			end
		end else if (sel < 86) begin
			seg_buf[0][7:0] = HDR_DUMMY;
		end else if (sel < 92) begin
			do
				hdr = 8'($urandom);
			while (hdr == HDR_TRIGGER || hdr == HDR_GATE || hdr == HDR_GATE_ALT
				|| hdr == HDR_DUMMY);
			seg_buf[0][7:0] = hdr;
		end
		// anything else stays as raw noise
		send_segment();
	endtask

	// hold the sender off until every expected result has been taken
	task automatic wait_for_results;
		marker_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [15:0] lim;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, reset limit of one, no idling ---

		// gate ahead of any trigger: dropped, and the rest of the segment skipped
		fill_random();
		for (int s = 0; s < 4; s++)
			put_sub(s, HDR_GATE, 32'd10, 8'd1, 32'd20, 8'd2);
		send_segment();

		// dummy gate header, then an unknown header
		fill_random();
		seg_buf[0][7:0] = HDR_DUMMY;
		send_segment();
		fill_random();
		seg_buf[0][7:0] = UNKNOWN_HDR;
		send_segment();

		// all-ones trigger fields
		send_trigger('1, '1, '1);

		// alternate header: first sub-marker is not a gate; then the widest gate,
		// a reversed gate and a one-block gate that rounds up
		fill_random();
		put_sub(0, HDR_GATE_ALT, '1, 8'hFF, '1, 8'hFF);
		put_sub(1, HDR_GATE, '0, 8'h00, '1, 8'hFF);
		put_sub(2, HDR_GATE, '1, 8'hFF, '0, 8'h00);
		put_sub(3, HDR_GATE, 32'd5, 8'h80, 32'd6, 8'h7F);
		send_segment();

		// all-zero trigger: second trigger passes the limit of one
		send_trigger('0, '0, '0);

		// empty gate, a non-gate and an unknown sub-marker, an exact multiple
		fill_random();
		put_sub(0, HDR_GATE, 32'h1234_5678, 8'h11, 32'h1234_5678, 8'h22);
		put_sub(1, OTHER_SUB, 32'd1, 8'd1, 32'd9, 8'd1);
		put_sub(2, UNKNOWN_HDR, 32'd1, 8'd1, 32'd9, 8'd1);
		put_sub(3, HDR_GATE, 32'd100, 8'd0, 32'd104, 8'd0);
		send_segment();

		// limit of zero: every trigger ends the read
		write_limit(16'd0);
		send_trigger(24'($urandom), $urandom, $urandom);
		send_trigger(24'($urandom), $urandom, $urandom);

		// --- random phases: limit and idle mix change at each boundary ---
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: lim = 16'd1;
				1: lim = 16'd0;
				2: lim = 16'd3;
				3: lim = 16'd7;
				4: lim = 16'($urandom_range(2, 40));
				default: lim = 16'hFFFF;
			endcase
			write_limit(lim);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 61;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 61;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			for (int n = 0; n < SEGMENTS_PER_PHASE; n++) begin
				random_segment();
				// one full drain mid-stream
				if (p == 1 && n == SEGMENTS_PER_PHASE / 2)
					wait_for_results();
			end
		end

		// --- widest gates under the largest limit, no idling ---
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_trigger(24'($urandom), $urandom, $urandom);
		for (int n = 0; n < SAT_SEGMENTS; n++) begin
			fill_random();
			for (int s = 0; s < 4; s++)
				put_sub(s, HDR_GATE, '0, 8'($urandom), '1, 8'($urandom));
			send_segment();
		end

		// a few more with both sides idling
		send_idle_pct = 31;
		recv_stall_pct = 31;
		for (int n = 0; n < TAIL_SEGMENTS; n++)
			random_segment();

		wait_for_results();
		repeat (END_TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
